[rtl/eer_pkg.sv]
// ----------------------------------------------------------------------------
// Electron event run decoder package
// Shared types and constants for the front parser, the back decoder and the
// top level.
// ----------------------------------------------------------------------------
package eer_pkg;

  localparam int RUN_W_MAX = 12;
  localparam int POS_W = 26;
  localparam logic [2:0] ELECTRON_CAP = 3'd7;

  typedef enum logic {
    FE_IDLE,
    FE_PARSE
  } fe_state_t;

  typedef struct packed {
    logic                 word_end;
    logic                 last_word;
    logic                 escape;
    logic [RUN_W_MAX-1:0] run;
  } eer_tok_t;

  typedef struct packed {
    logic [23:0] electron_index;
    logic [24:0] electron_count;
    logic        frame_done;
    logic        length_error;
    logic        last;
  } eer_res_t;

endpackage

[rtl/eer_fifo.sv]
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out queue of DEPTH entries with full and empty flags.
// ----------------------------------------------------------------------------
module eer_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == DEPTH_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/eer_front.sv]
// ----------------------------------------------------------------------------
// Electron event run decoder front end
// Accepts raw words, joins them to the carried bits and splits the stream
// into run codes, one code per cycle unless tok_full, then a word end marker.
// ----------------------------------------------------------------------------
module eer_front import eer_pkg::*; #(
  parameter int RUN_BITS      = 7,
  parameter int SUBPIXEL_BITS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [63:0] raw_word,
  input  logic        last_word,
  output logic        full,
  input  logic        tok_full,
  output logic        tok_push,
  output eer_tok_t    tok
);

  localparam int CODE_BITS = RUN_BITS + 2 * SUBPIXEL_BITS;
  localparam int BUF_W = 64 + CODE_BITS - 1;
  localparam int CNT_W = $clog2(BUF_W + 1);
  localparam logic [CNT_W-1:0] RUN_LEN = CNT_W'(RUN_BITS);
  localparam logic [CNT_W-1:0] CODE_LEN = CNT_W'(CODE_BITS);
  localparam logic [CNT_W-1:0] WORD_LEN = CNT_W'(64);
  localparam logic [RUN_BITS-1:0] RUN_ESCAPE = '1;

  fe_state_t          state;
  fe_state_t          state_next;
  logic [BUF_W-1:0]   bits;
  logic [BUF_W-1:0]   bits_next;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic               last_flag;
  logic               last_flag_next;
  logic [RUN_BITS-1:0] run;
  logic               esc;
  logic               have_code;

  assign run       = bits[RUN_BITS-1:0];
  assign esc       = (run == RUN_ESCAPE);
  assign have_code = (cnt >= RUN_LEN) && (esc || (cnt >= CODE_LEN));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FE_IDLE;
      bits      <= '0;
      cnt       <= '0;
      last_flag <= 1'b0;
    end else begin
      state     <= state_next;
      bits      <= bits_next;
      cnt       <= cnt_next;
      last_flag <= last_flag_next;
    end
  end

  always_comb begin
    state_next     = state;
    bits_next      = bits;
    cnt_next       = cnt;
    last_flag_next = last_flag;
    tok_push       = 1'b0;
    tok            = '0;
    full           = (state != FE_IDLE);
    case (state)
      FE_IDLE: begin
        if (push) begin
          bits_next      = bits | (BUF_W'(raw_word) << cnt);
          cnt_next       = cnt + WORD_LEN;
          last_flag_next = last_word;
          state_next     = FE_PARSE;
        end
      end
      FE_PARSE: begin
        if (!tok_full) begin
          tok_push = 1'b1;
          if (have_code) begin
            tok.escape = esc;
            tok.run    = RUN_W_MAX'(run);
            if (esc) begin
              bits_next = bits >> RUN_BITS;
              cnt_next  = cnt - RUN_LEN;
            end else begin
              bits_next = bits >> CODE_BITS;
              cnt_next  = cnt - CODE_LEN;
            end
          end else begin
            tok.word_end  = 1'b1;
            tok.last_word = last_flag;
            if (last_flag) begin
              bits_next = '0;
              cnt_next  = '0;
            end
            state_next = FE_IDLE;
          end
        end
      end
      default: begin
        state_next = FE_IDLE;
      end
    endcase
  end

endmodule

[rtl/eer_back.sv]
// ----------------------------------------------------------------------------
// Electron event run decoder back end
// Applies run codes to the pixel position, produces electron and done items,
// and holds one item back so that the last item of a word can be marked.
// ----------------------------------------------------------------------------
module eer_back import eer_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [24:0] limit,
  input  logic        tok_empty,
  input  eer_tok_t    tok,
  output logic        tok_pop,
  input  logic        res_full,
  output logic        res_push,
  output eer_res_t    res
);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [24:0]      total;
  logic [24:0]      total_next;
  logic             finished;
  logic             finished_next;
  logic [2:0]       k;
  logic [2:0]       k_next;
  logic             pend_valid;
  logic             pend_valid_next;
  eer_res_t         pend;
  eer_res_t         pend_next;
  logic [POS_W-1:0] lim;
  logic [POS_W-1:0] new_pos;
  logic             new_valid;
  eer_res_t         new_res;

  assign lim     = POS_W'(limit);
  assign new_pos = pos + POS_W'(tok.run);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      total      <= '0;
      finished   <= 1'b0;
      k          <= '0;
      pend_valid <= 1'b0;
    end else begin
      pos        <= pos_next;
      total      <= total_next;
      finished   <= finished_next;
      k          <= k_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
  end

  always_comb begin
    pos_next        = pos;
    total_next      = total;
    finished_next   = finished;
    k_next          = k;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    tok_pop         = 1'b0;
    res_push        = 1'b0;
    res             = pend;
    new_valid       = 1'b0;
    new_res         = '0;
    if (!tok_empty && (!pend_valid || !res_full)) begin
      if (tok.word_end) begin
        if (!finished && ((pos >= lim) || tok.last_word)) begin
          new_valid              = 1'b1;
          new_res.frame_done     = 1'b1;
          new_res.electron_count = total;
          finished_next          = 1'b1;
        end else begin
          tok_pop = 1'b1;
          k_next  = '0;
          if (pend_valid) begin
            res_push        = 1'b1;
            res.last        = 1'b1;
            pend_valid_next = 1'b0;
          end
          if (tok.last_word) begin
            pos_next      = '0;
            total_next    = '0;
            finished_next = 1'b0;
          end
        end
      end else begin
        tok_pop = 1'b1;
        if (!finished) begin
          if (pos >= lim) begin
            new_valid              = 1'b1;
            new_res.frame_done     = 1'b1;
            new_res.electron_count = total;
            finished_next          = 1'b1;
          end else if (new_pos >= lim) begin
            new_valid              = 1'b1;
            new_res.frame_done     = 1'b1;
            new_res.electron_count = total;
            new_res.length_error   = (new_pos > lim);
            finished_next          = 1'b1;
            pos_next               = new_pos;
          end else if (tok.escape) begin
            pos_next = new_pos;
          end else begin
            if (k != ELECTRON_CAP) begin
              new_valid              = 1'b1;
              new_res.electron_index = new_pos[23:0];
              k_next                 = k + 1'b1;
            end
            total_next = total + 1'b1;
            pos_next   = new_pos + 1'b1;
          end
        end
      end
      if (new_valid) begin
        if (pend_valid) begin
          res_push = 1'b1;
        end
        pend_next       = new_res;
        pend_valid_next = 1'b1;
      end
    end
  end

endmodule

[rtl/electron_event_run_decoder.sv]
// The front parser accepts a word, splits it into codes, one code per cycle
// while the token queue has room, and ends it with a word end marker; full is
// high while it parses. At the default settings a word holds five to ten codes.
// A word's last result enters the result queue as its word end marker is taken;
// one that closes the frame adds the done item first. Synchronous reset empties
// both queues, clears the frame state and sets the frame length to 16777216 pixels.
// ----------------------------------------------------------------------------
// Electron event run decoder
// Decodes run-length coded electron event frames into electron pixel indexes
// and one done item per frame.
// ----------------------------------------------------------------------------
module electron_event_run_decoder import eer_pkg::*; #(
  parameter int MAX_FRAME_PIXELS = 16777216,
  parameter int RUN_BITS         = 7,
  parameter int SUBPIXEL_BITS    = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        frame_pixels_wr,
  input  logic [24:0] frame_pixels,
  input  logic        push,
  input  logic [63:0] raw_word,
  input  logic        last_word,
  output logic        full,
  input  logic        pop,
  output logic        empty,
  output logic [23:0] electron_index,
  output logic [24:0] electron_count,
  output logic        frame_done,
  output logic        length_error,
  output logic        last
);

  localparam int TOK_DEPTH = 4;
  localparam int RES_DEPTH = 2;
  localparam int TOK_W = $bits(eer_tok_t);
  localparam int RES_W = $bits(eer_res_t);
  localparam logic [28:0] MAX_PIXELS = 29'(MAX_FRAME_PIXELS);

  logic [24:0]      frame_len;
  logic [28:0]      limit_wide;
  logic [24:0]      limit;
  logic             tok_push;
  logic             tok_full;
  logic             tok_pop;
  logic             tok_empty;
  eer_tok_t         tok_in;
  logic [TOK_W-1:0] tok_out;
  logic             res_push;
  logic             res_full;
  eer_res_t         res_in;
  logic [RES_W-1:0] res_out;
  eer_res_t         head;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_len <= 25'd16777216;
    end else if (frame_pixels_wr) begin
      frame_len <= frame_pixels;
    end
  end

  assign limit_wide = (29'(frame_len) > MAX_PIXELS) ? MAX_PIXELS : 29'(frame_len);
  assign limit      = limit_wide[24:0];

  eer_front #(
    .RUN_BITS      (RUN_BITS),
    .SUBPIXEL_BITS (SUBPIXEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .raw_word  (raw_word),
    .last_word (last_word),
    .full      (full),
    .tok_full  (tok_full),
    .tok_push  (tok_push),
    .tok       (tok_in)
  );

  eer_fifo #(
    .WIDTH (TOK_W),
    .DEPTH (TOK_DEPTH)
  ) u_tok_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (tok_push),
    .wdata (tok_in),
    .full  (tok_full),
    .pop   (tok_pop),
    .rdata (tok_out),
    .empty (tok_empty)
  );

  eer_back u_back (
    .clk       (clk),
    .rst       (rst),
    .limit     (limit),
    .tok_empty (tok_empty),
    .tok       (eer_tok_t'(tok_out)),
    .tok_pop   (tok_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  eer_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign head           = eer_res_t'(res_out);
  assign electron_index = head.electron_index;
  assign electron_count = head.electron_count;
  assign frame_done     = head.frame_done;
  assign length_error   = head.length_error;
  assign last           = head.last;

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_done) |-> last)
    else $error("done item not marked as last of its word");

  a_electron_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && !frame_done) |-> (!length_error && (electron_count == '0)))
    else $error("electron item carries done fields");

  a_done_no_index: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_done) |-> (electron_index == '0))
    else $error("done item carries an electron index");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("front accepted a word without parsing it");

endmodule

[test/electron_event_run_decoder_test.sv]
// ----------------------------------------------------------------------------
// Electron event run decoder test
// Feeds compressed frames, both packed code streams and raw noise words, under
// many frame lengths. A predictor decodes every accepted word and checks each
// electron item and frame done item in order, with random stalls on both
// sides and one long receiver stall that backs up the input.
// ----------------------------------------------------------------------------
module electron_event_run_decoder_test;
  import eer_pkg::*;

  localparam int unsigned RUN_LEN = 7;
  localparam int unsigned CODE_LEN = 11;
  localparam int unsigned ESCAPE_RUN = 127;
  localparam int unsigned MAX_PIXELS = 16777216;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned WORD_TARGET = 200;
  localparam int unsigned TIMEOUT_LIMIT = 2000000;

  typedef struct {
    logic [63:0] data;
    logic        is_last;
  } coded_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        frame_pixels_wr = 1'b0;
  logic [24:0] frame_pixels = '0;
  logic        push = 1'b0;
  logic [63:0] raw_word = '0;
  logic        last_word = 1'b0;
  logic        full;
  logic        pop = 1'b0;
  logic        empty;
  logic [23:0] electron_index;
  logic [24:0] electron_count;
  logic        frame_done;
  logic        length_error;
  logic        last;

  coded_word_t word_queue[$];
  eer_res_t    expected_results[$];
  eer_res_t    want;
  coded_word_t next_word;

  logic [127:0] stream_acc = '0;
  int unsigned  stream_len = 0;

  logic [63:0] carry_word = '0;
  int unsigned carry_len = 0;
  int unsigned pixel_pos = 0;
  int unsigned electrons = 0;
  bit          frame_full_seen = 1'b0;
  int unsigned frame_len_cfg = MAX_PIXELS;

  bit          steady_flow = 1'b0;
  int unsigned push_gap_left = 0;
  int unsigned pop_gap_left = 0;
  int unsigned pop_hold = 0;

  int unsigned mismatch_count = 0;
  int unsigned useful_words = 0;
  int unsigned words_queued = 0;
  int unsigned config_writes = 0;
  int unsigned electron_items_seen = 0;
  int unsigned done_items_seen = 0;
  int unsigned overshoot_seen = 0;
  int unsigned phase;

  electron_event_run_decoder i_dut (
    .clk            (clk),
    .rst            (rst),
    .frame_pixels_wr(frame_pixels_wr),
    .frame_pixels   (frame_pixels),
    .push           (push),
    .raw_word       (raw_word),
    .last_word      (last_word),
    .full           (full),
    .pop            (pop),
    .empty          (empty),
    .electron_index (electron_index),
    .electron_count (electron_count),
    .frame_done     (frame_done),
    .length_error   (length_error),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady_flow) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic void clear_frame_state();
    carry_word = '0;
    carry_len = 0;
    pixel_pos = 0;
    electrons = 0;
    frame_full_seen = 1'b0;
  endfunction

  // Decodes one accepted word and appends the items it causes.
  function automatic void decode_word(logic [63:0] w, logic lw);
    logic [127:0] bits;
    int unsigned  pos;
    int unsigned  total;
    int unsigned  limit;
    int unsigned  run;
    bit           done;
    bit           overshoot;
    eer_res_t     items[$];
    eer_res_t     r;
    if (frame_full_seen) begin
      if (lw) clear_frame_state();
      return;
    end
    useful_words++;
    bits = {64'b0, carry_word} | ({64'b0, w} << carry_len);
    total = carry_len + 64;
    pos = 0;
    done = 1'b0;
    overshoot = 1'b0;
    limit = (frame_len_cfg > MAX_PIXELS) ? MAX_PIXELS : frame_len_cfg;
    if (pixel_pos >= limit) done = 1'b1;
    while (!done && total - pos >= RUN_LEN) begin
      run = 32'(bits[pos +: RUN_LEN]);
      if (run != ESCAPE_RUN && total - pos < CODE_LEN) break;
      pos += (run != ESCAPE_RUN) ? CODE_LEN : RUN_LEN;
      pixel_pos += run;
      if (pixel_pos >= limit) begin
        done = 1'b1;
        overshoot = pixel_pos > limit;
      end else if (run != ESCAPE_RUN) begin
        if (items.size() < 32'(ELECTRON_CAP)) begin
          r = '0;
          r.electron_index = 24'(pixel_pos);
          items.push_back(r);
        end
        electrons++;
        pixel_pos++;
        if (pixel_pos >= limit) done = 1'b1;
      end
    end
    if (done || lw) begin
      r = '0;
      r.electron_count = 25'(electrons);
      r.frame_done = 1'b1;
      r.length_error = overshoot;
      items.push_back(r);
      if (lw) begin
        clear_frame_state();
      end else begin
        frame_full_seen = 1'b1;
        carry_word = '0;
        carry_len = 0;
      end
    end else begin
      carry_len = total - pos;
      carry_word = 64'((bits >> pos) & ((128'd1 << carry_len) - 1));
    end
    if (items.size() != 0) items[items.size() - 1].last = 1'b1;
    foreach (items[i]) expected_results.push_back(items[i]);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_value);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("Mismatch at %0t: %s is %0d, expected %0d.", $time, what, got, exp_value);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) decode_word(raw_word, last_word);
      if (!push || !full) begin
        if (push_gap_left > 0) begin
          push_gap_left--;
          push <= 1'b0;
        end else if (word_queue.size() != 0) begin
          next_word = word_queue.pop_front();
          push <= 1'b1;
          raw_word <= next_word.data;
          last_word <= next_word.is_last;
          push_gap_left = pick_gap();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("item with nothing expected, frame_done", 32'(frame_done), 0);
        end else begin
          want = expected_results.pop_front();
          if (electron_index !== want.electron_index)
            report_mismatch("electron_index", 32'(electron_index), 32'(want.electron_index));
          if (electron_count !== want.electron_count)
            report_mismatch("electron_count", 32'(electron_count), 32'(want.electron_count));
          if (frame_done !== want.frame_done)
            report_mismatch("frame_done", 32'(frame_done), 32'(want.frame_done));
          if (length_error !== want.length_error)
            report_mismatch("length_error", 32'(length_error), 32'(want.length_error));
          if (last !== want.last)
            report_mismatch("last", 32'(last), 32'(want.last));
          if (want.frame_done) done_items_seen++;
          else electron_items_seen++;
          if (want.length_error) overshoot_seen++;
        end
        pop_gap_left = pick_gap();
      end
      if (pop_hold > 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else if (pop_gap_left > 0) begin
        pop_gap_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic void queue_word(logic [63:0] data, logic is_last);
    word_queue.push_back('{data: data, is_last: is_last});
    words_queued++;
  endfunction

  function automatic void put_bits(logic [63:0] value, int unsigned width);
    stream_acc |= (({64'b0, value}) & ((128'd1 << width) - 1)) << stream_len;
    stream_len += width;
    if (stream_len >= 64) begin
      queue_word(stream_acc[63:0], 1'b0);
      stream_acc >>= 64;
      stream_len -= 64;
    end
  endfunction

  function automatic void put_code(int unsigned run);
    put_bits(64'(run), RUN_LEN);
    if (run != ESCAPE_RUN) put_bits({$urandom, $urandom}, CODE_LEN - RUN_LEN);
  endfunction

  // The final word carries the remaining stream bits, padded with zeros or noise.
  function automatic void end_frame(bit zero_pad);
    logic [63:0] pad;
    pad = zero_pad ? 64'd0 : {$urandom, $urandom};
    queue_word(stream_acc[63:0] | (pad << stream_len), 1'b1);
    stream_acc = '0;
    stream_len = 0;
  endfunction

  function automatic void queue_random_frame();
    int unsigned style;
    int unsigned n_codes;
    style = $urandom_range(9);
    if (style == 0) begin
      repeat ($urandom_range(3, 0)) queue_word({$urandom, $urandom}, 1'b0);
      queue_word({$urandom, $urandom}, 1'b1);
    end else begin
      n_codes = $urandom_range(36, 2);
      repeat (n_codes) begin
        if (style <= 2) put_code($urandom_range(3));
        else if ($urandom_range(99) < 15) put_code(ESCAPE_RUN);
        else put_code($urandom_range(ESCAPE_RUN - 1));
      end
      end_frame($urandom_range(1));
    end
  endfunction

  function automatic int unsigned pick_frame_len();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(20, 1);
      2, 3, 4: return $urandom_range(3000, 50);
      5: return MAX_PIXELS;
      6: return 25'h1FFFFFF;
      7: return $urandom_range(25'h1FFFFFF, MAX_PIXELS + 1);
      default: return $urandom_range(800, 100);
    endcase
  endfunction

  // Words dropped after a full frame cause no item, so the block gets time to settle.
  task automatic wait_drained();
    @(negedge clk);
    while (word_queue.size() != 0 || push || expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_frame_len(logic [24:0] value);
    @(posedge clk);
    frame_pixels_wr <= 1'b1;
    frame_pixels <= value;
    frame_len_cfg = value;
    config_writes++;
    @(posedge clk);
    frame_pixels_wr <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    #TIMEOUT_LIMIT;
    $display("[electron_event_run_decoder] ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default length: dense electrons, then escapes, then a mixed stream.
    queue_word(64'd0, 1'b0);
    queue_word('1, 1'b1);
    put_code(0);
    put_code(ESCAPE_RUN - 1);
    put_code(ESCAPE_RUN);
    put_code(5);
    put_code(ESCAPE_RUN);
    put_code(ESCAPE_RUN);
    put_code(0);
    put_code(3);
    end_frame(1'b1);
    wait_drained();

    // A zero length frame is full before any code is read.
    write_frame_len(25'd0);
    queue_word({$urandom, $urandom}, 1'b0);
    queue_word({$urandom, $urandom}, 1'b0);
    queue_word({$urandom, $urandom}, 1'b1);
    queue_word({$urandom, $urandom}, 1'b1);
    wait_drained();

    // Runs that hit the end exactly, overshoot it, and an electron that fills it.
    write_frame_len(25'd10);
    put_code(10);
    put_code(3);
    end_frame(1'b1);
    put_code(12);
    repeat (8) put_code(0);
    end_frame(1'b0);
    put_code(3);
    put_code(5);
    end_frame(1'b1);
    wait_drained();

    write_frame_len(25'h1FFFFFF);
    repeat (9) put_code(ESCAPE_RUN);
    put_code(0);
    end_frame(1'b0);
    wait_drained();

    write_frame_len(25'd1);
    put_code(0);
    end_frame(1'b1);
    put_code(2);
    end_frame(1'b1);
    wait_drained();

    phase = 0;
    while (words_queued < WORD_TARGET) begin
      wait_drained();
      if (phase == 1) begin
        // The receiver stalls while the sender keeps offering words.
        write_frame_len(25'(MAX_PIXELS));
        steady_flow = 1'b1;
        pop_hold = 300;
        repeat (8) queue_random_frame();
      end else begin
        write_frame_len(25'(pick_frame_len()));
        steady_flow = (phase % 5 == 3);
        repeat ($urandom_range(5, 2)) queue_random_frame();
      end
      phase++;
    end
    wait_drained();

    $display("Sent %0d words, %0d of them decoded, over %0d frame length settings.",
             words_queued, useful_words, config_writes);
    $display("Checked %0d electron items and %0d frame done items, %0d with a length error.",
             electron_items_seen, done_items_seen, overshoot_seen);
    if (mismatch_count == 0) begin
      $display("[electron_event_run_decoder] OK");
    end else begin
      $display("[electron_event_run_decoder] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/eer_pkg.sv
rtl/eer_fifo.sv
rtl/eer_front.sv
rtl/eer_back.sv
rtl/electron_event_run_decoder.sv
test/electron_event_run_decoder_test.sv
